@@ sv/fmms_pkg.sv @@
`timescale 1ns / 1ps

package fmms_pkg;

   // Result word field widths
   localparam int MEAN_W  = 16;
   localparam int DEV_W   = 16;
   localparam int COUNT_W = 13;

   // Squared deviation accumulator (unsigned Q30.16) and its square root
   localparam int SQ_W  = 46;
   localparam int AD_W  = SQ_W / 2;
   localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};

   // Saturation limits
   localparam int MEAN_POS_MAX  = 32767;
   localparam int MEAN_NEG_MAG  = 32768;
   localparam int DEV_MAX       = 65535;
   localparam int DEV_ONE       = 256;
   localparam int COUNT_MAX     = 8191;

   // Controller phases
   typedef enum logic [2:0] {
      PH_LOAD,
      PH_MEAN_START,
      PH_MEAN_WAIT,
      PH_WALK,
      PH_DEV_WAIT,
      PH_SQRT_WAIT,
      PH_EMIT
   } phase_type;

endpackage

@@ sv/fmms_req_if.sv @@
`timescale 1ns / 1ps

interface fmms_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

@@ sv/fmms_rsp_if.sv @@
`timescale 1ns / 1ps

interface fmms_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fmms_pkg::MEAN_W-1:0]  mean_value;
   logic        [fmms_pkg::DEV_W-1:0]   deviation;
   logic        [fmms_pkg::COUNT_W-1:0] sample_count;

   modport source (output valid, output mean_value, output deviation,
                   output sample_count, input ready);
   modport sink   (input valid, input mean_value, input deviation,
                   input sample_count, output ready);
endinterface

@@ sv/fmms_ram.sv @@
`timescale 1ns / 1ps

module fmms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/fmms_divider.sv @@
`timescale 1ns / 1ps

module fmms_divider #(
   parameter int NUM_W = 46,
   parameter int DEN_W = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              ge;

   // Restoring division, one quotient bit per cycle, MSB first
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         den_in  = den;
         rem_in  = '0;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;

endmodule

@@ sv/fmms_sqrt.sv @@
`timescale 1ns / 1ps

module fmms_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fmms_pkg::SQ_W-1:0]  radicand,
   output logic                       done,
   output logic [fmms_pkg::AD_W-1:0]  root,
   output logic [fmms_pkg::AD_W:0]    remainder
);

   localparam int QW     = fmms_pkg::SQ_W;
   localparam int RW     = fmms_pkg::AD_W;
   localparam int STEP_W = $clog2(RW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [QW-1:0]     rad_ff, rad_in;
   logic [RW:0]       rem_ff, rem_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [RW+2:0]     shifted;
   logic [RW+2:0]     trial;
   logic [RW+2:0]     diff;
   logic              ge;

   // Digit recurrence, two radicand bits per cycle; remainder ends as q - root^2
   always_comb begin
      shifted = {rem_ff, rad_ff[QW-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = shifted - trial;
      ge      = shifted >= trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(RW);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = ge ? diff[RW:0] : shifted[RW:0];
         root_in = {root_ff[RW-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done      = done_ff;
   assign root      = root_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/feature_map_mean_std_stats.sv @@
`timescale 1ns / 1ps

// Feature map mean and standard deviation. Signed Q8.8 samples stream in on
// req at one word per cycle in the load phase and are written to a sample
// store RAM while the running sum and nonzero count are updated; samples past
// STORE_DEPTH are dropped but a last flag on them still closes the set. After
// the word marked last, req is held off while the block divides the sum by the
// sample count (rounded, or zero when zero_mean_mode is set or no samples were
// loaded), walks the store through a four-stage read/square/accumulate pipe,
// divides the squared deviation sum by nonzero count plus one, and takes a
// rounded square root (zero reads as 1.0). One rsp word (mean, deviation,
// count) follows. The mean and deviation divisions share one serial divider
// of width W (46 at default sizes, one quotient bit per cycle), and the square
// root unit resolves one bit per cycle. The store needs no clearing after
// reset. A finished rsp word can wait while the next set loads.
module feature_map_mean_std_stats #(
   parameter int STORE_DEPTH = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   fmms_req_if.sink   req,
   fmms_rsp_if.source rsp,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   localparam int AW    = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int RS_W  = SAMPLE_BITS + CNT_W;
   localparam int NUM_W = (RS_W > fmms_pkg::SQ_W) ? RS_W : fmms_pkg::SQ_W;
   localparam int DEN_W = CNT_W + 1;
   localparam int D_W   =
      ((SAMPLE_BITS > fmms_pkg::MEAN_W) ? SAMPLE_BITS : fmms_pkg::MEAN_W) + 1;
   localparam int SQ_W  = fmms_pkg::SQ_W;
   localparam int RW    = fmms_pkg::AD_W;
   localparam int MW    = fmms_pkg::MEAN_W;

   fmms_pkg::phase_type state_ff, state_in;

   logic                     zero_mode_ff;
   logic signed [RS_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]         nz_ff, nz_in;
   logic [CNT_W-1:0]         loaded_ff, loaded_in;
   logic [SQ_W-1:0]          sqsum_ff, sqsum_in;
   logic signed [MW-1:0]     mean_ff, mean_in;
   logic                     mean_neg_ff, mean_neg_in;
   logic [fmms_pkg::DEV_W-1:0] dev_ff, dev_in;

   // walk pipeline
   logic [CNT_W-1:0]         rd_cnt_ff, rd_cnt_in;
   logic                     v1_ff, v1_in;
   logic                     v2_ff;
   logic                     v3_ff;
   logic [RW-1:0]            ad_ff;
   logic                     big_ff;
   logic [SQ_W-1:0]          sq_ff;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [MW-1:0]     rsp_mean_ff;
   logic [fmms_pkg::DEV_W-1:0]   rsp_dev_ff;
   logic [fmms_pkg::COUNT_W-1:0] rsp_cnt_ff;

   logic                     take;
   logic                     store_wr;
   logic                     emit_fire;
   logic [SAMPLE_BITS-1:0]   rd_data;
   logic signed [D_W-1:0]    diff;
   logic [D_W-1:0]           ad_full;
   logic [SQ_W-1:0]          prod;
   logic [SQ_W:0]            acc;
   logic [RS_W-1:0]          mag;
   logic                     div_start;
   logic [NUM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic                     div_busy;
   logic                     div_done;
   logic [NUM_W-1:0]         div_quot;
   logic                     sqrt_start;
   logic                     sqrt_done;
   logic [RW-1:0]            sqrt_root;
   logic [RW:0]              sqrt_rem;
   logic [RW:0]              root_rnd;
   logic [fmms_pkg::COUNT_W-1:0] cnt_sat;

   assign req.ready = (state_ff == fmms_pkg::PH_LOAD);
   assign take      = req.valid && req.ready;
   assign store_wr  = take && (loaded_ff < CNT_W'(STORE_DEPTH));
   assign emit_fire = (state_ff == fmms_pkg::PH_EMIT) && (!rsp_valid_ff || rsp.ready);

   // sample store
   fmms_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data (req.sample),
      .rd_en   (v1_in),
      .rd_addr (rd_cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // shared serial divider: mean first, then deviation quotient
   fmms_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   fmms_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .start     (sqrt_start),
      .radicand  (div_quot[SQ_W-1:0]),
      .done      (sqrt_done),
      .root      (sqrt_root),
      .remainder (sqrt_rem)
   );

   // datapath helpers
   always_comb begin
      mag      = sum_ff[RS_W-1] ? RS_W'(-sum_ff) : RS_W'(sum_ff);
      diff     = D_W'($signed(rd_data)) - D_W'(mean_ff);
      ad_full  = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
      prod     = ad_ff * ad_ff;
      acc      = {1'b0, sqsum_ff} + {1'b0, sq_ff};
      root_rnd = ({1'b0, sqrt_root} < sqrt_rem) ? ({1'b0, sqrt_root} + (RW+1)'(1))
                                                : {1'b0, sqrt_root};
      cnt_sat  = (32'(loaded_ff) > 32'(fmms_pkg::COUNT_MAX))
                 ? fmms_pkg::COUNT_W'(fmms_pkg::COUNT_MAX)
                 : fmms_pkg::COUNT_W'(loaded_ff);
      if (state_ff == fmms_pkg::PH_MEAN_START) begin
         div_num = NUM_W'(mag) + NUM_W'(loaded_ff >> 1);
         div_den = DEN_W'(loaded_ff);
      end else begin
         div_num = NUM_W'(sqsum_ff);
         div_den = DEN_W'(nz_ff) + DEN_W'(1);
      end
   end

   // controller
   always_comb begin
      state_in    = state_ff;
      sum_in      = sum_ff;
      nz_in       = nz_ff;
      loaded_in   = loaded_ff;
      sqsum_in    = sqsum_ff;
      mean_in     = mean_ff;
      mean_neg_in = mean_neg_ff;
      dev_in      = dev_ff;
      rd_cnt_in   = rd_cnt_ff;
      v1_in       = 1'b0;
      div_start   = 1'b0;
      sqrt_start  = 1'b0;

      if (v3_ff) begin
         sqsum_in = acc[SQ_W] ? fmms_pkg::SQ_MAX : acc[SQ_W-1:0];
      end

      case (state_ff)
         fmms_pkg::PH_LOAD: begin
            if (store_wr) begin
               sum_in    = sum_ff + RS_W'(req.sample);
               nz_in     = (req.sample != '0) ? nz_ff + CNT_W'(1) : nz_ff;
               loaded_in = loaded_ff + CNT_W'(1);
            end
            if (take && req.last) begin
               state_in = fmms_pkg::PH_MEAN_START;
            end
         end
         fmms_pkg::PH_MEAN_START: begin
            rd_cnt_in   = '0;
            mean_neg_in = sum_ff[RS_W-1];
            if (zero_mode_ff || (loaded_ff == '0)) begin
               mean_in  = '0;
               state_in = fmms_pkg::PH_WALK;
            end else begin
               div_start = 1'b1;
               state_in  = fmms_pkg::PH_MEAN_WAIT;
            end
         end
         fmms_pkg::PH_MEAN_WAIT: begin
            if (div_done) begin
               if (mean_neg_ff) begin
                  mean_in = (div_quot > NUM_W'(fmms_pkg::MEAN_NEG_MAG))
                            ? MW'(-fmms_pkg::MEAN_NEG_MAG)
                            : MW'(0) - MW'(div_quot);
               end else begin
                  mean_in = (div_quot > NUM_W'(fmms_pkg::MEAN_POS_MAX))
                            ? MW'(fmms_pkg::MEAN_POS_MAX)
                            : MW'(div_quot);
               end
               state_in = fmms_pkg::PH_WALK;
            end
         end
         fmms_pkg::PH_WALK: begin
            if (rd_cnt_ff < loaded_ff) begin
               v1_in     = 1'b1;
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            end else if (!v1_ff && !v2_ff && !v3_ff) begin
               div_start = 1'b1;
               state_in  = fmms_pkg::PH_DEV_WAIT;
            end
         end
         fmms_pkg::PH_DEV_WAIT: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               state_in   = fmms_pkg::PH_SQRT_WAIT;
            end
         end
         fmms_pkg::PH_SQRT_WAIT: begin
            if (sqrt_done) begin
               if (root_rnd > (RW+1)'(fmms_pkg::DEV_MAX)) begin
                  dev_in = fmms_pkg::DEV_W'(fmms_pkg::DEV_MAX);
               end else if (root_rnd == '0) begin
                  dev_in = fmms_pkg::DEV_W'(fmms_pkg::DEV_ONE);
               end else begin
                  dev_in = fmms_pkg::DEV_W'(root_rnd);
               end
               state_in = fmms_pkg::PH_EMIT;
            end
         end
         fmms_pkg::PH_EMIT: begin
            if (emit_fire) begin
               sum_in    = '0;
               nz_in     = '0;
               loaded_in = '0;
               sqsum_in  = '0;
               state_in  = fmms_pkg::PH_LOAD;
            end
         end
         default: begin
            state_in = fmms_pkg::PH_LOAD;
         end
      endcase
   end

   // output word handshake
   always_comb begin
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmms_pkg::PH_LOAD;
         zero_mode_ff <= 1'b0;
         sum_ff       <= '0;
         nz_ff        <= '0;
         loaded_ff    <= '0;
         sqsum_ff     <= '0;
         rd_cnt_ff    <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            zero_mode_ff <= csr_wr_data;
         end
         sum_ff       <= sum_in;
         nz_ff        <= nz_in;
         loaded_ff    <= loaded_in;
         sqsum_ff     <= sqsum_in;
         rd_cnt_ff    <= rd_cnt_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mean_ff     <= mean_in;
      mean_neg_ff <= mean_neg_in;
      dev_ff      <= dev_in;
      ad_ff       <= RW'(ad_full);
      big_ff      <= (ad_full >> RW) != '0;
      sq_ff       <= big_ff ? fmms_pkg::SQ_MAX : prod;
      if (emit_fire) begin
         rsp_mean_ff <= mean_ff;
         rsp_dev_ff  <= dev_ff;
         rsp_cnt_ff  <= cnt_sat;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.mean_value   = rsp_mean_ff;
   assign rsp.deviation    = rsp_dev_ff;
   assign rsp.sample_count = rsp_cnt_ff;

   // checks
   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CNT_W'(STORE_DEPTH))
      else $error("loaded count above store depth");

   a_nz_bound: assert property (@(posedge clock) disable iff (reset)
      nz_ff <= loaded_ff)
      else $error("nonzero count above loaded count");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fmms_pkg::PH_WALK) |-> (rd_cnt_ff <= loaded_ff))
      else $error("walk read past loaded samples");

   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (loaded_ff == '0) && rsp_valid_ff && (sqsum_ff == '0))
      else $error("set not cleared after result");

endmodule
